@@ src/chroma_cone_pixel_classifier_top_defines.svh @@
// Assertion macros for the chroma cone pixel classifier.
// Expects clk and rst in the scope where a macro is used.
`ifndef CHROMA_CONE_PIXEL_CLASSIFIER_TOP_DEFINES_SVH
`define CHROMA_CONE_PIXEL_CLASSIFIER_TOP_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define CCPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define CCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccpc_pkg.sv @@
// Shared types and constants of the chroma cone pixel classifier.
// No dependencies.
`default_nettype none

package ccpc_pkg;

  localparam int CHROMA_BITS_DEF = 16;
  localparam int REG_BITS = 16;
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WPT_RED     = 3'd0,
    REG_WPT_GREEN   = 3'd1,
    REG_HUE_SINE    = 3'd2,
    REG_HUE_COSINE  = 3'd3,
    REG_CONE_COS_SQ = 3'd4,
    REG_SAT_MIN_SQ  = 3'd5,
    REG_SAT_MAX_SQ  = 3'd6
  } ccpc_reg_t;

  typedef struct packed {
    logic        [REG_BITS-1:0] wpt_red;
    logic        [REG_BITS-1:0] wpt_green;
    logic signed [REG_BITS-1:0] hue_sine;
    logic signed [REG_BITS-1:0] hue_cosine;
    logic        [REG_BITS-1:0] cone_cos_sq;
    logic        [REG_BITS-1:0] sat_min_sq;
    logic        [REG_BITS-1:0] sat_max_sq;
  } ccpc_cfg_t;

  // control between front and back halves of the pipe
  typedef struct packed {
    logic valid;
    logic band_ok;
  } ccpc_ctl_t;

  localparam ccpc_cfg_t CFG_RST = '{
    wpt_red:     16'd21845,
    wpt_green:   16'd21845,
    hue_sine:    -16'sd23170,
    hue_cosine:  -16'sd23170,
    cone_cos_sq: 16'd57870,
    sat_min_sq:  16'd164,
    sat_max_sq:  16'd16384
  };

endpackage

`default_nettype wire

@@ src/ccpc_cfg_regs.sv @@
// Configuration register file of the chroma cone pixel classifier.
// Depends on ccpc_pkg.
`default_nettype none

module ccpc_cfg_regs import ccpc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    write_enable,
  input  wire logic [REG_IDX_BITS-1:0] write_index,
  input  wire logic [REG_BITS-1:0]     write_data,
  output ccpc_cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (write_enable) begin
      unique case (write_index)
        REG_WPT_RED:     cfg.wpt_red     <= write_data;
        REG_WPT_GREEN:   cfg.wpt_green   <= write_data;
        REG_HUE_SINE:    cfg.hue_sine    <= write_data;
        REG_HUE_COSINE:  cfg.hue_cosine  <= write_data;
        REG_CONE_COS_SQ: cfg.cone_cos_sq <= write_data;
        REG_SAT_MIN_SQ:  cfg.sat_min_sq  <= write_data;
        REG_SAT_MAX_SQ:  cfg.sat_max_sq  <= write_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ccpc_front.sv @@
// Front pipe stages: white point offset, squares and hue products, L2/D sums.
// Depends on ccpc_pkg.
`default_nettype none

module ccpc_front import ccpc_pkg::*; #(
  parameter int CHROMA_BITS = CHROMA_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ccpc_cfg_t                 cfg,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [15:0]               red_chroma,
  input  wire logic [15:0]               green_chroma,
  output ccpc_ctl_t                      mid,
  input  wire logic                      mid_ready,
  output logic [2*CHROMA_BITS:0]         l2,
  output logic [CHROMA_BITS+16:0]        mag
);

  localparam int C  = CHROMA_BITS;
  localparam int PW = C + 17;

  logic ready1, ready2, ready3;
  logic v1, v2, v3;

  // stage 1: offsets
  logic        [C-1:0] red_c, green_c, wr_c, wg_c;
  logic signed [C:0]   x1, y1;

  // stage 2: products
  logic signed [2*C+1:0] sqx_full, sqy_full;
  logic signed [PW-1:0]  sx_next, sy_next;
  logic        [2*C-1:0] sqx, sqy;
  logic signed [PW-1:0]  sx, sy;

  // stage 3: sums and band test
  logic        [2*C:0]   l2_next, smin, smax;
  logic signed [PW:0]    d_next;
  logic                  ok_next;
  logic                  ok3;

  assign ready3   = !v3 || mid_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  assign red_c   = C'(red_chroma);
  assign green_c = C'(green_chroma);
  assign wr_c    = C'(cfg.wpt_red);
  assign wg_c    = C'(cfg.wpt_green);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      x1 <= $signed({1'b0, red_c}) - $signed({1'b0, wr_c});
      y1 <= $signed({1'b0, green_c}) - $signed({1'b0, wg_c});
    end
  end

  assign sqx_full = (2*C+2)'(x1) * (2*C+2)'(x1);
  assign sqy_full = (2*C+2)'(y1) * (2*C+2)'(y1);
  assign sx_next  = PW'(cfg.hue_sine) * PW'(x1);
  assign sy_next  = PW'(cfg.hue_cosine) * PW'(y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      sqx <= sqx_full[2*C-1:0];
      sqy <= sqy_full[2*C-1:0];
      sx  <= sx_next;
      sy  <= sy_next;
    end
  end

  assign l2_next = {1'b0, sqx} + {1'b0, sqy};
  assign d_next  = (PW+1)'(sx) + (PW+1)'(sy);
  assign smin    = (2*C+1)'(cfg.sat_min_sq) << (2*C-16);
  assign smax    = (2*C+1)'(cfg.sat_max_sq) << (2*C-16);
  assign ok_next = (l2_next > smin) && (l2_next < smax) &&
                   !d_next[PW] && (d_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      l2  <= l2_next;
      mag <= d_next[PW-1:0];
      ok3 <= ok_next;
    end
  end

  assign mid.valid   = v3;
  assign mid.band_ok = ok3;

endmodule

`default_nettype wire

@@ src/ccpc_back.sv @@
// Back pipe stages: split D squared and cone bound products, final compare.
// Depends on ccpc_pkg.
`default_nettype none

module ccpc_back import ccpc_pkg::*; #(
  parameter int CHROMA_BITS = CHROMA_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ccpc_cfg_t                 cfg,
  input  wire ccpc_ctl_t                 mid,
  output logic                           mid_ready,
  input  wire logic [2*CHROMA_BITS:0]    l2,
  input  wire logic [CHROMA_BITS+16:0]   mag,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           is_target
);

  localparam int C   = CHROMA_BITS;
  localparam int W   = C + 17;
  localparam int L   = (W + 1) / 2;
  localparam int H   = W - L;
  localparam int LW  = 2 * C + 1;
  localparam int RPW = LW + 16;
  localparam int SW  = 2 * W;

  logic ready4, ready5;
  logic v4, ok4;

  logic [H-1:0]     mag_hi;
  logic [L-1:0]     mag_lo;
  logic [2*H-1:0]   hh;
  logic [H+L-1:0]   hl;
  logic [2*L-1:0]   lo;
  logic [RPW-1:0]   rp;
  logic [SW-1:0]    dsq, rhs;

  assign ready5    = !out_valid || !out_stall;
  assign ready4    = !v4 || ready5;
  assign mid_ready = ready4;

  assign mag_hi = mag[W-1:L];
  assign mag_lo = mag[L-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && mid.valid) begin
      hh  <= (2*H)'(mag_hi) * (2*H)'(mag_hi);
      hl  <= (H+L)'(mag_hi) * (H+L)'(mag_lo);
      lo  <= (2*L)'(mag_lo) * (2*L)'(mag_lo);
      rp  <= RPW'(cfg.cone_cos_sq) * RPW'(l2);
      ok4 <= mid.band_ok;
    end
  end

  // D^2 = hi^2 * 2^2L + 2 * hi * lo * 2^L + lo^2
  assign dsq = (SW'(hh) << (2*L)) + (SW'(hl) << (L+1)) + SW'(lo);
  assign rhs = SW'(rp) << 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      is_target <= ok4 && (dsq > rhs);
    end
  end

endmodule

`default_nettype wire

@@ src/chroma_cone_pixel_classifier_top.sv @@
// Chroma cone pixel classifier top: config registers and a five-stage pipe.
// Throughput one item per cycle while out_stall is low; the split D squared
// multiply and final wide compare set the depth.
// Synchronous active-high reset clears valid bits and loads register defaults.
// Depends on ccpc_pkg, ccpc_cfg_regs, ccpc_front, ccpc_back and the defines header.
`default_nettype none
`include "chroma_cone_pixel_classifier_top_defines.svh"

module chroma_cone_pixel_classifier_top import ccpc_pkg::*; #(
  parameter int CHROMA_BITS = CHROMA_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    write_enable,
  input  wire logic [REG_IDX_BITS-1:0] write_index,
  input  wire logic [REG_BITS-1:0]     write_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [15:0]             red_chroma,
  input  wire logic [15:0]             green_chroma,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         is_target
);

  ccpc_cfg_t                    cfg;
  ccpc_ctl_t                    mid;
  logic                         mid_ready;
  logic [2*CHROMA_BITS:0]       l2;
  logic [CHROMA_BITS+16:0]      mag;

  ccpc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  ccpc_front #(.CHROMA_BITS(CHROMA_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red_chroma   (red_chroma),
    .green_chroma (green_chroma),
    .mid          (mid),
    .mid_ready    (mid_ready),
    .l2           (l2),
    .mag          (mag)
  );

  ccpc_back #(.CHROMA_BITS(CHROMA_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid       (mid),
    .mid_ready (mid_ready),
    .l2        (l2),
    .mag       (mag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_target (is_target)
  );

  `CCPC_ASSERT_NOW(a_empty_out_takes_in, !out_valid, !in_stall, "input stalled with empty output")
  `CCPC_ASSERT_NEXT(a_mid_holds, mid.valid && !mid_ready, mid.valid && $stable(mid.band_ok), "mid item lost under stall")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for chroma_cone_pixel_classifier_top: directed and random pixels under
// several register settings, each result checked against an in-bench cone predictor.
// Depends on ccpc_pkg and the classifier RTL.

module tb;
  import ccpc_pkg::*;

  localparam logic [REG_IDX_BITS-1:0] REG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
  } pixel_t;

  logic clk;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [REG_IDX_BITS-1:0] write_index = '0;
  logic [REG_BITS-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] red_chroma = '0;
  logic [15:0] green_chroma = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_target;

  // shadow of the register file, loaded with the documented reset values
  ccpc_cfg_t cfg = '{16'd21845, 16'd21845, -16'sd23170, -16'sd23170,
                     16'd57870, 16'd164, 16'd16384};

  pixel_t pixel_q[$];
  logic want_target_q[$];
  pixel_t next_pixel;
  logic want_bit;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned stall_draw;
  int mismatches = 0;
  bit burst = 1'b0;

  chroma_cone_pixel_classifier_top u_dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red_chroma(red_chroma),
    .green_chroma(green_chroma),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_target(is_target)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact cone test: band on L2, D > 0, D^2 > cone_cos_sq * L2 (aligned by 2^14)
  function automatic logic in_cone(input logic [15:0] r, input logic [15:0] g);
    longint x, y, l2, d, s, c, smin, smax;
    logic [127:0] d_sq, lim;
    logic hit;
    x = longint'({48'd0, r}) - longint'({48'd0, cfg.wpt_red});
    y = longint'({48'd0, g}) - longint'({48'd0, cfg.wpt_green});
    s = longint'($signed(cfg.hue_sine));
    c = longint'($signed(cfg.hue_cosine));
    l2 = x * x + y * y;
    d = s * x + c * y;
    smin = longint'({48'd0, cfg.sat_min_sq}) << 16;
    smax = longint'({48'd0, cfg.sat_max_sq}) << 16;
    hit = 1'b0;
    if (smin < l2 && l2 < smax && d > 0) begin
      d_sq = 128'(d);
      d_sq = d_sq * d_sq;
      lim = 128'(cfg.cone_cos_sq) * 128'(l2);
      lim = lim << 14;
      hit = d_sq > lim;
    end
    return hit;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        want_target_q.push_back(in_cone(red_chroma, green_chroma));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          next_pixel = pixel_q.pop_front();
          in_valid <= 1'b1;
          red_chroma <= next_pixel.red;
          green_chroma <= next_pixel.green;
          send_gap <= burst ? 0 : $urandom_range(0, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_target_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item is_target=%0b", $time, is_target);
        end else begin
          want_bit = want_target_q.pop_front();
          if (is_target !== want_bit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: is_target expected %0b got %0b", $time, want_bit, is_target);
          end
        end
        stall_draw = burst ? 0 : $urandom_range(0, 13);
        recv_wait <= stall_draw;
        out_stall <= (stall_draw != 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_stall <= (recv_wait > 1);
      end
    end
  end

  task automatic add_pixel(input logic [15:0] r, input logic [15:0] g);
    pixel_q.push_back('{red: r, green: g});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || want_target_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    case (idx)
      REG_WPT_RED:     cfg.wpt_red = val;
      REG_WPT_GREEN:   cfg.wpt_green = val;
      REG_HUE_SINE:    cfg.hue_sine = val;
      REG_HUE_COSINE:  cfg.hue_cosine = val;
      REG_CONE_COS_SQ: cfg.cone_cos_sq = val;
      REG_SAT_MIN_SQ:  cfg.sat_min_sq = val;
      REG_SAT_MAX_SQ:  cfg.sat_max_sq = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input ccpc_cfg_t nc);
    write_reg(REG_WPT_RED, nc.wpt_red);
    write_reg(REG_WPT_GREEN, nc.wpt_green);
    write_reg(REG_HUE_SINE, nc.hue_sine);
    write_reg(REG_HUE_COSINE, nc.hue_cosine);
    write_reg(REG_CONE_COS_SQ, nc.cone_cos_sq);
    write_reg(REG_SAT_MIN_SQ, nc.sat_min_sq);
    write_reg(REG_SAT_MAX_SQ, nc.sat_max_sq);
    write_reg(REG_IDX_SPARE, 16'($urandom()));
    @(posedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // mostly pixels placed around the hue direction inside (or just past) the band
  task automatic random_items(input int n);
    int k, mode;
    real sr, cr, hl, ux, uy, rad, f, px, py;
    int unsigned lo, hi;
    logic [15:0] r, g;
    for (k = 0; k < n; k++) begin
      mode = $urandom_range(0, 19);
      sr = $signed(cfg.hue_sine);
      cr = $signed(cfg.hue_cosine);
      hl = $sqrt(sr * sr + cr * cr);
      if (mode < 14 && hl >= 1.0) begin
        ux = sr / hl;
        uy = cr / hl;
        lo = (cfg.sat_min_sq * 3) / 4;
        hi = cfg.sat_max_sq + cfg.sat_max_sq / 4;
        rad = $sqrt(real'($urandom_range(hi, lo)) * 65536.0);
        f = real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0;
        px = real'(cfg.wpt_red) + rad * (ux + f * uy);
        py = real'(cfg.wpt_green) + rad * (uy - f * ux);
        if (px < 0.0) px = 0.0;
        if (px > 65535.0) px = 65535.0;
        if (py < 0.0) py = 0.0;
        if (py > 65535.0) py = 65535.0;
        r = 16'($rtoi(px));
        g = 16'($rtoi(py));
      end else if (mode < 19) begin
        r = 16'($urandom());
        g = 16'($urandom());
      end else begin
        r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      add_pixel(r, g);
    end
  endtask

  initial begin
    ccpc_cfg_t nc;
    int ph, sv, cv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset settings: white at 1/3, hue pointing away from red and green
    add_pixel(16'd21845, 16'd21845);
    add_pixel(16'd18845, 16'd18845);
    add_pixel(16'd0, 16'd0);
    add_pixel(16'd65535, 16'd65535);
    add_pixel(16'd0, 16'd65535);
    add_pixel(16'd65535, 16'd0);
    add_pixel(16'd18845, 16'd21845);
    add_pixel(16'd19845, 16'd18845);
    random_items(60);
    wait_idle();

    // band edges hit exactly: hue along -x, no cone limit, band 256..512
    burst = 1'b1;
    load_config('{16'd32768, 16'd32768, 16'h8000, 16'sd0, 16'd0, 16'd1, 16'd4});
    add_pixel(16'd32512, 16'd32768);
    add_pixel(16'd32511, 16'd32768);
    add_pixel(16'd32257, 16'd32768);
    add_pixel(16'd32256, 16'd32768);
    add_pixel(16'd33068, 16'd32768);
    add_pixel(16'd32768, 16'd33068);
    add_pixel(16'd32468, 16'd32568);
    add_pixel(16'd0, 16'd65535);
    add_pixel(16'd65535, 16'd0);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      sv = int'($urandom_range(0, 65535)) - 32768;
      cv = $rtoi($sqrt(real'(1073741824 - sv * sv)));
      if (cv > 32767) cv = 32767;
      if ($urandom_range(0, 1)) cv = -cv;
      if (ph % 2 == 1) begin
        sv = int'($urandom_range(0, 65535)) - 32768;
        cv = int'($urandom_range(0, 65535)) - 32768;
      end
      nc.wpt_red = $urandom_range(8000, 40000);
      nc.wpt_green = $urandom_range(8000, 40000);
      nc.hue_sine = sv[15:0];
      nc.hue_cosine = cv[15:0];
      nc.cone_cos_sq = $urandom_range(0, 65535);
      nc.sat_max_sq = $urandom_range(1000, 40000);
      nc.sat_min_sq = $urandom_range(0, nc.sat_max_sq - 1);
      case (ph)
        0: nc = '{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'h8000, 16'hFFFF, 16'd0, 16'hFFFF};
        1: nc = '0;
        2: nc.sat_min_sq = nc.sat_max_sq;
        3: begin
          nc.sat_min_sq = $urandom_range(20000, 65535);
          nc.sat_max_sq = $urandom_range(0, nc.sat_min_sq - 1);
        end
        4: begin
          nc.wpt_red = 16'd0;
          nc.wpt_green = 16'd0;
          nc.hue_sine = 16'h8000;
          nc.hue_cosine = 16'sh7FFF;
          nc.cone_cos_sq = 16'd0;
          nc.sat_min_sq = 16'd0;
          nc.sat_max_sq = 16'hFFFF;
        end
        default: ;
      endcase
      burst = (ph % 2 == 1);
      load_config(nc);
      random_items(55);
      wait_idle();
    end

    repeat (12) @(negedge clk);
    if (mismatches == 0 && want_target_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ccpc_pkg.sv
src/ccpc_cfg_regs.sv
src/ccpc_front.sv
src/ccpc_back.sv
src/chroma_cone_pixel_classifier_top.sv
tb/sv/tb.sv
